// File: rtl/core/hamming_single_error_decoder_core_macros.svh
// Assertion macros shared by the decoder core.
`ifndef HAMMING_SINGLE_ERROR_DECODER_CORE_MACROS_SVH
`define HAMMING_SINGLE_ERROR_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSED_ASSERT_IMPLY(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HSED_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/hsed_pkg.sv
package hsed_pkg;

    localparam int CODEWORD_W = 64;
    localparam int DATA_W     = 57;
    localparam int SYN_W      = 7;
    localparam int DLEN_W     = 6;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_ODD  = 1'd1;

    localparam logic [DLEN_W-1:0] DATA_LENGTH_RESET = 6'd4;

    // Decoding setup derived from the configuration registers.
    typedef struct packed {
        logic              parity_odd;
        logic [SYN_W-1:0]  code_len;
    } cfg_t;

    // Masked codeword and its syndrome, handed to the correction logic.
    typedef struct packed {
        logic [CODEWORD_W-1:0] word;
        logic [SYN_W-1:0]      syndrome;
    } syn_t;

    // Smallest parity count p with d + p + 1 <= 2^p.
    function automatic logic [2:0] parity_count(input logic [DLEN_W-1:0] d);
        logic [2:0] p;
        logic       found;
        p     = 3'd7;
        found = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (!found && (int'(d) + k + 1 <= (1 << k))) begin
                p     = 3'(k);
                found = 1'b1;
            end
        end
        return p;
    endfunction

    // Largest data length whose codeword fits in code_bits positions.
    function automatic logic [DLEN_W-1:0] max_data_length(input int code_bits);
        logic [DLEN_W-1:0] r;
        r = '0;
        for (int d = 0; d <= DATA_W; d++) begin
            if (d + int'(parity_count(DLEN_W'(d))) <= code_bits) begin
                r = DLEN_W'(d);
            end
        end
        return r;
    endfunction

    // Bits covered by parity group i, excluding the parity bit itself.
    function automatic logic [CODEWORD_W-1:0] group_mask(input int i);
        logic [CODEWORD_W-1:0] m;
        m = '0;
        for (int pos = 1; pos <= CODEWORD_W; pos++) begin
            m[pos-1] = (((pos >> i) & 1) == 1) && (pos != (1 << i));
        end
        return m;
    endfunction

    // Zero-based codeword bit that carries data bit k.
    function automatic int data_bit_index(input int k);
        int cnt;
        int idx;
        cnt = 0;
        idx = 0;
        for (int pos = 1; pos <= CODEWORD_W; pos++) begin
            if ((pos & (pos - 1)) != 0) begin
                if (cnt == k) begin
                    idx = pos - 1;
                end
                cnt++;
            end
        end
        return idx;
    endfunction

endpackage

// File: rtl/core/hsed_if.sv
interface hsed_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [hsed_pkg::CODEWORD_W-1:0]      codeword;

    modport source (output valid, output codeword, input ready);
    modport sink (input valid, input codeword, output ready);
endinterface

interface hsed_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [hsed_pkg::DATA_W-1:0]          data_bits;
    logic                                 no_error;
    logic [hsed_pkg::SYN_W-1:0]           error_position;
    logic                                 position_invalid;

    modport source (output valid, output data_bits, output no_error,
                    output error_position, output position_invalid, input ready);
    modport sink (input valid, input data_bits, input no_error,
                  input error_position, input position_invalid, output ready);
endinterface

// File: rtl/core/hsed_cfg.sv
module hsed_cfg #(
    parameter int CODE_BITS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hsed_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hsed_pkg::DLEN_W-1:0]       cfg_wdata,
    output hsed_pkg::cfg_t                    cfg
);

    localparam logic [hsed_pkg::DLEN_W-1:0] DATA_LENGTH_MAX =
        hsed_pkg::max_data_length(CODE_BITS);

    logic [hsed_pkg::DLEN_W-1:0] data_length_reg;
    logic                        parity_odd_reg;
    logic [hsed_pkg::DLEN_W-1:0] data_length_eff;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            data_length_reg <= hsed_pkg::DATA_LENGTH_RESET;
            parity_odd_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                hsed_pkg::CFG_DATA_LENGTH: data_length_reg <= cfg_wdata;
                hsed_pkg::CFG_PARITY_ODD:  parity_odd_reg  <= cfg_wdata[0];
                default:                   data_length_reg <= data_length_reg;
            endcase
        end
    end

    // Lengths whose codeword would not fit are clamped to the largest that does.
    assign data_length_eff = (data_length_reg > DATA_LENGTH_MAX) ? DATA_LENGTH_MAX
                                                                 : data_length_reg;

    assign cfg.parity_odd = parity_odd_reg;
    assign cfg.code_len   = {1'b0, data_length_eff}
                          + {4'b0, hsed_pkg::parity_count(data_length_eff)};

endmodule

// File: rtl/core/hsed_syndrome.sv
module hsed_syndrome (
    input  logic [hsed_pkg::CODEWORD_W-1:0] codeword,
    input  hsed_pkg::cfg_t                  cfg,
    output hsed_pkg::syn_t                  syn
);

    logic [hsed_pkg::CODEWORD_W-1:0] word;

    // Positions beyond the codeword length read as zero.
    for (genvar b = 0; b < hsed_pkg::CODEWORD_W; b++) begin : g_mask
        assign word[b] = codeword[b] & (cfg.code_len > hsed_pkg::SYN_W'(b));
    end

    // A parity group exists only if its parity position lies inside the codeword.
    for (genvar i = 0; i < hsed_pkg::SYN_W; i++) begin : g_syn
        localparam logic [hsed_pkg::CODEWORD_W-1:0] MASK = hsed_pkg::group_mask(i);
        localparam logic [hsed_pkg::SYN_W-1:0]      GROUP_POS = hsed_pkg::SYN_W'(1 << i);
        assign syn.syndrome[i] = (cfg.code_len >= GROUP_POS)
                               & ((^(word & MASK)) ^ cfg.parity_odd ^ word[(1 << i) - 1]);
    end

    assign syn.word = word;

endmodule

// File: rtl/core/hsed_correct.sv
module hsed_correct (
    input  hsed_pkg::syn_t                  syn,
    input  logic [hsed_pkg::SYN_W-1:0]      code_len,
    output logic [hsed_pkg::DATA_W-1:0]     data_bits,
    output logic                            no_error,
    output logic                            position_invalid
);

    logic [hsed_pkg::CODEWORD_W-1:0] fixed_word;

    assign position_invalid = syn.syndrome > code_len;
    assign no_error         = syn.syndrome == '0;

    // Flip the addressed bit only when the syndrome points inside the codeword.
    for (genvar b = 0; b < hsed_pkg::CODEWORD_W; b++) begin : g_flip
        assign fixed_word[b] = syn.word[b]
                             ^ (!position_invalid && (syn.syndrome == hsed_pkg::SYN_W'(b + 1)));
    end

    // Data bits sit at fixed positions; masking already zeroes those past the length.
    for (genvar k = 0; k < hsed_pkg::DATA_W; k++) begin : g_data
        assign data_bits[k] = fixed_word[hsed_pkg::data_bit_index(k)];
    end

endmodule

// File: rtl/core/hamming_single_error_decoder_core.sv
// A codeword taken into the input register is decoded into the result register.
// Throughput: one codeword per cycle while results.ready holds; the XOR trees, bit flip
// and data extraction sit in a single stage between the input register and the result register.
// Reset (rst_n, asynchronous, active low) empties both pipeline stages and sets
// the data length to 4 and the parity type to even.
`include "hamming_single_error_decoder_core_macros.svh"

module hamming_single_error_decoder_core #(
    parameter int CODE_BITS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hsed_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hsed_pkg::DLEN_W-1:0]       cfg_wdata,
    hsed_in_if.sink                           codewords,
    hsed_out_if.source                        results
);

    // Configuration registers and the codeword length derived from them.
    hsed_pkg::cfg_t cfg;

    hsed_cfg #(
        .CODE_BITS (CODE_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Input stage. The result register parts the two sides, so a new beat can be taken
    // into an empty input stage while a finished result is still waiting downstream.
    logic                            in_valid_reg;
    logic [hsed_pkg::CODEWORD_W-1:0] codeword_reg;

    // Result stage.
    logic                            out_valid_reg;
    logic [hsed_pkg::DATA_W-1:0]     data_bits_reg;
    logic                            no_error_reg;
    logic [hsed_pkg::SYN_W-1:0]      error_position_reg;
    logic                            position_invalid_reg;

    logic                            out_free;
    logic                            advance;

    // The result register can load when it is empty or is being drained this cycle.
    assign out_free        = !out_valid_reg || results.ready;
    assign advance         = in_valid_reg && out_free;
    assign codewords.ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (codewords.ready) begin
                in_valid_reg <= codewords.valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (codewords.valid && codewords.ready) begin
            codeword_reg <= codewords.codeword;
        end
    end

    // Decode logic between the two registers.
    hsed_pkg::syn_t              syn;
    logic [hsed_pkg::DATA_W-1:0] data_bits_next;
    logic                        no_error_next;
    logic [hsed_pkg::SYN_W-1:0]  error_position_next;
    logic                        position_invalid_next;

    hsed_syndrome u_syndrome (
        .codeword (codeword_reg),
        .cfg      (cfg),
        .syn      (syn)
    );

    hsed_correct u_correct (
        .syn              (syn),
        .code_len         (cfg.code_len),
        .data_bits        (data_bits_next),
        .no_error         (no_error_next),
        .position_invalid (position_invalid_next)
    );

    assign error_position_next = syn.syndrome;

    always_ff @(posedge clk) begin
        if (advance) begin
            data_bits_reg        <= data_bits_next;
            no_error_reg         <= no_error_next;
            error_position_reg   <= error_position_next;
            position_invalid_reg <= position_invalid_next;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.data_bits        = data_bits_reg;
    assign results.no_error         = no_error_reg;
    assign results.error_position   = error_position_reg;
    assign results.position_invalid = position_invalid_reg;

    // A codeword leaving the input stage must land in the result stage.
    `HSED_ASSERT_NEXT(a_advance_fills_result, clk, rst_n, advance, out_valid_reg, "result stage did not load")

    // The no-error flag and the reported position must agree.
    `HSED_ASSERT_IMPLY(a_no_error_matches_position, clk, rst_n, out_valid_reg, no_error_reg == (error_position_reg == '0), "no_error disagrees with error_position")

    // An out-of-range flag must come with a syndrome beyond the codeword length.
    `HSED_ASSERT_IMPLY(a_invalid_beyond_length, clk, rst_n, out_valid_reg && position_invalid_reg, error_position_reg > cfg.code_len, "position_invalid with in-range syndrome")

endmodule

// File: sim/tb_hamming_single_error_decoder_core.sv
// Testbench for the Hamming single-error decoder core.
//
// Codewords go in on one valid/ready channel and one correction result per
// codeword comes out on the other. Every accepted input beat gets an entry in
// a queue of pending corrections. That entry is either a value typed into the
// directed table or the output of a local predictor. Every accepted output
// beat is checked field by field against the oldest pending correction.
module tb_hamming_single_error_decoder_core;

    import hsed_pkg::*;

    localparam int CODE_BITS   = 64;
    // The receiver blocks this many cycles once, so that both pipeline
    // stages fill and the input side has to stall.
    localparam int HOLD_CYCLES = 120;
    localparam int PHASES      = 10;
    localparam int PHASE_BEATS = 55;

    // One decoded result, in the same field layout as the output channel.
    typedef struct packed {
        logic [DATA_W-1:0] data_bits;
        logic              no_error;
        logic [SYN_W-1:0]  error_position;
        logic              position_invalid;
    } correction_t;

    // One row of the directed table. When typed is set, want holds the
    // result that is easy to work out by hand. Otherwise the predictor
    // supplies the expected result.
    typedef struct {
        logic [DLEN_W-1:0]     dlen;
        logic                  odd;
        logic [CODEWORD_W-1:0] codeword;
        bit                    typed;
        correction_t           want;
    } probe_t;

    localparam logic [DATA_W-1:0] ALL_DATA = {DATA_W{1'b1}};

    // The rows move through the corner cases: the reset setting, words that
    // are already clean, single flipped bits, junk above the codeword length,
    // odd parity, an empty codeword, a syndrome that points past the
    // codeword, the longest legal data length, and lengths above it that
    // saturate to the longest one.
    probe_t probes [24] = '{
        '{6'd4,  1'b0, 64'h0,                   1'b1, '{57'h0, 1'b1, 7'd0, 1'b0}},
        '{6'd4,  1'b0, 64'h7f,                  1'b1, '{57'hf, 1'b1, 7'd0, 1'b0}},
        '{6'd4,  1'b0, 64'h6f,                  1'b1, '{57'hf, 1'b0, 7'd5, 1'b0}},
        '{6'd4,  1'b0, 64'hffff_ffff_ffff_ff80, 1'b1, '{57'h0, 1'b1, 7'd0, 1'b0}},
        '{6'd4,  1'b0, 64'hffff_ffff_ffff_ffff, 1'b1, '{57'hf, 1'b1, 7'd0, 1'b0}},
        '{6'd4,  1'b0, 64'h35,                  1'b0, '{57'h0, 1'b0, 7'd0, 1'b0}},
        '{6'd4,  1'b1, 64'h0,                   1'b1, '{57'h8, 1'b0, 7'd7, 1'b0}},
        '{6'd4,  1'b1, 64'h7f,                  1'b1, '{57'h7, 1'b0, 7'd7, 1'b0}},
        '{6'd4,  1'b1, 64'h5a,                  1'b0, '{57'h0, 1'b0, 7'd0, 1'b0}},
        '{6'd0,  1'b0, 64'hffff_ffff_ffff_ffff, 1'b1, '{57'h0, 1'b1, 7'd0, 1'b0}},
        '{6'd0,  1'b1, 64'h1234,                1'b1, '{57'h0, 1'b1, 7'd0, 1'b0}},
        '{6'd1,  1'b0, 64'h0,                   1'b1, '{57'h0, 1'b1, 7'd0, 1'b0}},
        '{6'd1,  1'b0, 64'h7,                   1'b1, '{57'h1, 1'b1, 7'd0, 1'b0}},
        '{6'd1,  1'b0, 64'h4,                   1'b1, '{57'h0, 1'b0, 7'd3, 1'b0}},
        '{6'd5,  1'b0, 64'h8b,                  1'b1, '{57'h0, 1'b0, 7'd15, 1'b1}},
        '{6'd5,  1'b1, 64'h0,                   1'b1, '{57'h0, 1'b0, 7'd15, 1'b1}},
        '{6'd57, 1'b0, 64'h0,                   1'b1, '{57'h0, 1'b1, 7'd0, 1'b0}},
        '{6'd57, 1'b0, 64'hffff_ffff_ffff_ffff, 1'b1, '{ALL_DATA, 1'b1, 7'd0, 1'b0}},
        '{6'd57, 1'b1, 64'hffff_ffff_ffff_ffff, 1'b1,
          '{57'h0ff_ffff_ffff_ffff, 1'b0, 7'd63, 1'b0}},
        '{6'd57, 1'b0, 64'hdead_beef_0123_4567, 1'b0, '{57'h0, 1'b0, 7'd0, 1'b0}},
        '{6'd63, 1'b0, 64'hffff_ffff_ffff_ffff, 1'b1, '{ALL_DATA, 1'b1, 7'd0, 1'b0}},
        '{6'd63, 1'b1, 64'h8000_0000_0000_0001, 1'b0, '{57'h0, 1'b0, 7'd0, 1'b0}},
        '{6'd12, 1'b0, 64'h0000_0000_0000_a5c3, 1'b0, '{57'h0, 1'b0, 7'd0, 1'b0}},
        '{6'd30, 1'b1, 64'h0000_0000_3c96_1e0f, 1'b0, '{57'h0, 1'b0, 7'd0, 1'b0}}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DLEN_W-1:0]    cfg_wdata;

    hsed_in_if  codeword_bus ();
    hsed_out_if result_bus ();

    hamming_single_error_decoder_core #(
        .CODE_BITS (CODE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .codewords (codeword_bus),
        .results   (result_bus)
    );

    // Local copy of the two configuration registers. It changes only while
    // nothing is in flight, so it is valid for every beat that is accepted.
    logic [DLEN_W-1:0] shadow_dlen;
    logic              shadow_odd;

    correction_t pending_corrections [$];
    int          mismatches;

    // The sender posts the typed expectation of the beat it offers here.
    // The monitor reads it at the edge that accepts the beat.
    bit          offered_typed;
    correction_t offered_want;

    // steady switches off the random gaps on both sides for one phase.
    // hold_request asks the receiver for its one long hold-off.
    bit steady;
    bit hold_request;
    int idle_left;

    correction_t seen;
    correction_t oldest;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("tb_hamming_single_error_decoder_core: FAIL");
        $finish;
    end

    // Smallest check bit count p with d + p + 1 <= 2^p.
    function automatic int check_bits_for(input int d);
        int p;
        p = 0;
        while (d + p + 1 > (1 << p))
            p++;
        return p;
    endfunction

    // A data length whose codeword would not fit is cut down to the longest
    // one that fits.
    function automatic int usable_length(input logic [DLEN_W-1:0] dlen);
        int d;
        d = int'(dlen);
        while (d > 0 && d + check_bits_for(d) > CODE_BITS)
            d--;
        return d;
    endfunction

    function automatic logic [CODEWORD_W-1:0] low_mask(input int n);
        if (n >= CODEWORD_W)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    // Predicts the result of one codeword under the given setting. It builds
    // the syndrome from the check groups, flips the bit the syndrome points
    // to if that bit lies inside the codeword, and packs the data positions.
    function automatic correction_t correct_codeword(input logic [CODEWORD_W-1:0] cw,
                                                     input logic [DLEN_W-1:0] dlen,
                                                     input logic odd);
        correction_t           r;
        logic [CODEWORD_W-1:0] w;
        int                    d;
        int                    p;
        int                    n;
        int                    syn;
        int                    g;
        int                    cnt;
        int                    k;
        d   = usable_length(dlen);
        p   = check_bits_for(d);
        n   = d + p;
        w   = cw & low_mask(n);
        syn = 0;
        for (int i = 0; i < p; i++)
        begin
            g   = 1 << i;
            cnt = 0;
            for (int pos = 1; pos <= n; pos++)
            begin
                if ((pos & g) != 0 && pos != g)
                    cnt += int'(w[pos-1]);
            end
            // Odd parity expects the complement of the plain group parity.
            if ((cnt[0] ^ odd) != w[g-1])
                syn += g;
        end
        r.position_invalid = (syn > n);
        if (syn > 0 && syn <= n)
            w[syn-1] = ~w[syn-1];
        r.data_bits = '0;
        k = 0;
        for (int pos = 1; pos <= n; pos++)
        begin
            if ((pos & (pos - 1)) != 0)
            begin
                r.data_bits[k] = w[pos-1];
                k++;
            end
        end
        r.no_error       = (syn == 0);
        r.error_position = SYN_W'(syn);
        return r;
    endfunction

    // Builds a clean codeword that carries the given data bits.
    function automatic logic [CODEWORD_W-1:0] build_codeword(input logic [DATA_W-1:0] payload,
                                                             input logic [DLEN_W-1:0] dlen,
                                                             input logic odd);
        logic [CODEWORD_W-1:0] w;
        int                    n;
        int                    p;
        int                    k;
        int                    g;
        int                    cnt;
        p = check_bits_for(usable_length(dlen));
        n = usable_length(dlen) + p;
        w = '0;
        k = 0;
        for (int pos = 1; pos <= n; pos++)
        begin
            if ((pos & (pos - 1)) != 0)
            begin
                w[pos-1] = payload[k];
                k++;
            end
        end
        for (int i = 0; i < p; i++)
        begin
            g   = 1 << i;
            cnt = 0;
            for (int pos = 1; pos <= n; pos++)
            begin
                if ((pos & g) != 0 && pos != g)
                    cnt += int'(w[pos-1]);
            end
            w[g-1] = cnt[0] ^ odd;
        end
        return w;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Called at a falling edge. Offers one beat, waits for the edge that
    // accepts it, and returns at the falling edge after that, sometimes
    // after a gap with valid low.
    task automatic send_beat(input logic [CODEWORD_W-1:0] cw, input bit typed,
                             input correction_t want);
        offered_typed = typed;
        offered_want  = want;
        codeword_bus.valid    <= 1'b1;
        codeword_bus.codeword <= cw;
        do
            @(posedge clk);
        while (!codeword_bus.ready);
        @(negedge clk);
        if (!steady && $urandom_range(0, 99) < 30)
        begin
            codeword_bus.valid <= 1'b0;
            repeat (pick_gap()) @(negedge clk);
        end
    endtask

    // Lowers valid and waits until every pending result has come out and the
    // two pipeline stages have gone idle. Returns at a falling edge.
    task automatic drain();
        codeword_bus.valid <= 1'b0;
        while (pending_corrections.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        @(negedge clk);
    endtask

    // Write enable stays high across back to back writes. The caller lowers
    // it after the last one.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DLEN_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
    endtask

    task automatic set_config(input logic [DLEN_W-1:0] dlen, input logic odd);
        drain();
        write_register(CFG_DATA_LENGTH, dlen);
        write_register(CFG_PARITY_ODD, DLEN_W'(odd));
        cfg_we      <= 1'b0;
        shadow_dlen  = dlen;
        shadow_odd   = odd;
    endtask

    // Receiver side. It either counts down a hold-off or takes beats, and
    // now and then starts a new random gap.
    initial
    begin
        result_bus.ready = 1'b0;
        idle_left        = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                idle_left    = HOLD_CYCLES;
            end
            if (idle_left > 0)
            begin
                result_bus.ready <= 1'b0;
                idle_left--;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 25)
                    idle_left = pick_gap();
            end
        end
    end

    // Monitor. Both channels are sampled at the rising edge. The input beat
    // is booked before the output beat is checked, so a result never finds
    // the queue in a state that depends on process order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (codeword_bus.valid && codeword_bus.ready)
            begin
                if (offered_typed)
                    pending_corrections.push_back(offered_want);
                else
                    pending_corrections.push_back(correct_codeword(codeword_bus.codeword,
                                                                   shadow_dlen, shadow_odd));
            end
            if (result_bus.valid && result_bus.ready)
            begin
                seen.data_bits        = result_bus.data_bits;
                seen.no_error         = result_bus.no_error;
                seen.error_position   = result_bus.error_position;
                seen.position_invalid = result_bus.position_invalid;
                if (pending_corrections.size() == 0)
                    report_mismatch("result beat with nothing pending", 64'(seen), 64'h0);
                else
                begin
                    oldest = pending_corrections.pop_front();
                    if (seen.data_bits !== oldest.data_bits)
                        report_mismatch("data_bits", 64'(seen.data_bits),
                                        64'(oldest.data_bits));
                    if (seen.no_error !== oldest.no_error)
                        report_mismatch("no_error", 64'(seen.no_error),
                                        64'(oldest.no_error));
                    if (seen.error_position !== oldest.error_position)
                        report_mismatch("error_position", 64'(seen.error_position),
                                        64'(oldest.error_position));
                    if (seen.position_invalid !== oldest.position_invalid)
                        report_mismatch("position_invalid", 64'(seen.position_invalid),
                                        64'(oldest.position_invalid));
                end
            end
        end
    end

    initial
    begin
        logic [CODEWORD_W-1:0] cw;
        logic [DATA_W-1:0]     payload;
        logic [DLEN_W-1:0]     dlen;
        logic                  odd;
        int                    n;
        int                    kind;
        correction_t           none;

        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_wdata             = '0;
        codeword_bus.valid    = 1'b0;
        codeword_bus.codeword = '0;
        shadow_dlen           = DATA_LENGTH_RESET;
        shadow_odd            = 1'b0;
        mismatches            = 0;
        offered_typed         = 1'b0;
        offered_want          = '0;
        steady                = 1'b0;
        hold_request          = 1'b0;
        none                  = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. The first rows run on the reset setting with no
        // write at all. After that the setting is changed only when a row
        // needs a different one.
        foreach (probes[i])
        begin
            if (probes[i].dlen != shadow_dlen || probes[i].odd != shadow_odd)
                set_config(probes[i].dlen, probes[i].odd);
            send_beat(probes[i].codeword, probes[i].typed, probes[i].want);
        end

        // Random part. Each phase picks a setting; the first phases force the
        // longest length, the shortest, a saturating one and a short one with
        // spare syndrome values. Most beats are well-formed codewords, clean
        // or with one flipped bit, with junk above the codeword length; the
        // rest are raw random words.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: dlen = 6'd57;
                1: dlen = 6'd1;
                2: dlen = 6'($urandom_range(58, 63));
                3: dlen = 6'd5;
                default: dlen = 6'($urandom_range(1, 57));
            endcase
            odd = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
            set_config(dlen, odd);
            steady = (ph == 3 || ph == 7);
            if (ph == 1)
                hold_request = 1'b1;
            n = usable_length(dlen) + check_bits_for(usable_length(dlen));
            for (int b = 0; b < PHASE_BEATS; b++)
            begin
                kind    = $urandom_range(0, 99);
                payload = DATA_W'({$urandom, $urandom});
                if (kind < 75)
                begin
                    cw = build_codeword(payload, dlen, odd);
                    if (kind >= 20)
                        cw[$urandom_range(1, n) - 1] ^= 1'b1;
                    cw |= {$urandom, $urandom} & ~low_mask(n);
                end
                else
                    cw = {$urandom, $urandom};
                send_beat(cw, 1'b0, none);
            end
        end

        drain();
        if (mismatches == 0)
            $display("tb_hamming_single_error_decoder_core: PASS");
        else
            $display("tb_hamming_single_error_decoder_core: FAIL");
        $finish;
    end

endmodule
